/* rtl/cove_pkg.sv */
// Shared types, constants and codes for the command-line option value extractor.
// No dependencies; every other file of the block imports this package.
package cove_pkg;

    // Default line capacity for the top-level parameter
    localparam int LINE_CAPACITY_DEF = 2048;

    // Key and buffer limits
    localparam int KEY_MAX   = 16;
    localparam int KEY_BYTES = 16;
    localparam int LIMIT_CAP = 2048;

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int LEN_W     = 12;
    localparam int KPOS_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 64;

    // Saturation point of the value count
    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

    // Characters with a meaning to the scanner
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd3;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    // Search status codes
    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_BOOL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    // Clamped configuration as seen by the scanner
    typedef struct packed {
        logic [8*KEY_BYTES-1:0] key;
        logic [KPOS_W-1:0]      klen;
        logic [LEN_W-1:0]       lim;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic              write_valid;
        logic [IDX_W-1:0]  write_index;
        logic [CHAR_W-1:0] write_byte;
        logic              done_res;
        status_t           status;
        logic [LEN_W-1:0]  value_length;
        logic              last;
    } result_t;

endpackage

/* rtl/cmdline_option_value_extractor.sv */
// Command-line option value extractor: takes one character per beat and, for the
// configured key, writes the value bytes and a closing zero into a result buffer
// and reports a status and the full value length at each line end, or a bare-key
// status when the key stands alone. A character is taken every cycle unless the
// input stalls; each one passes an input register and one scan step and lands in
// a four-beat result queue. Most characters yield no result or one; a value byte
// written on the last line position yields two, and the input stalls only while
// the result queue holds more than two beats that the consumer has not taken.
// Depends on cove_pkg, cove_cfg, cove_scan and cove_rfifo.
module cmdline_option_value_extractor
    import cove_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAR_W-1:0]    s_char_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_write_valid,
    output logic [IDX_W-1:0]     m_write_index,
    output logic [CHAR_W-1:0]    m_write_byte,
    output logic                 m_done_res,
    output logic [1:0]           m_status,
    output logic [LEN_W-1:0]     m_value_length,
    output logic                 m_last
);

    cfg_t              cfg;
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              room;
    logic              step_en;
    logic              s_beat;
    result_t           res0;
    result_t           res1;
    logic [1:0]        res_count;
    logic [1:0]        push_count;
    result_t           head;

    cove_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Input register: hold the character until the queue can take its results
    assign step_en       = in_valid_reg && room;
    assign s_ready       = !in_valid_reg || room;
    assign s_beat        = s_valid && s_ready;
    assign in_valid_next = s_beat ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_char_reg <= s_char_in;
        end
    end

    cove_scan #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .ch        (in_char_reg),
        .cfg       (cfg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    assign push_count = step_en ? res_count : 2'd0;

    cove_rfifo u_rfifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .pop        (m_valid && m_ready),
        .has_room   (room),
        .out_valid  (m_valid),
        .out_data   (head)
    );

    // Drive the result beat from the queue head
    assign m_write_valid  = head.write_valid;
    assign m_write_index  = head.write_index;
    assign m_write_byte   = head.write_byte;
    assign m_done_res     = head.done_res;
    assign m_status       = head.status;
    assign m_value_length = head.value_length;
    assign m_last         = head.last;

endmodule

/* rtl/cove_cfg.sv */
// Configuration registers of the option value extractor, with range clamping.
// Depends on cove_pkg.
module cove_cfg
    import cove_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wr_data,
    output cfg_t                 cfg
);

    logic [CFG_DW-1:0] key_low_reg,  key_low_next;
    logic [CFG_DW-1:0] key_high_reg, key_high_next;
    logic [KPOS_W-1:0] key_len_reg,  key_len_next;
    logic [LEN_W-1:0]  limit_reg,    limit_next;

    // Decode the register write
    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        key_len_next  = key_len_reg;
        limit_next    = limit_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_next  = cfg_wr_data;
                REG_KEY_HIGH: key_high_next = cfg_wr_data;
                REG_KEY_LEN:  key_len_next  = cfg_wr_data[KPOS_W-1:0];
                REG_LIMIT:    limit_next    = cfg_wr_data[LEN_W-1:0];
                default: begin
                    key_low_next = key_low_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
            limit_reg    <= '0;
        end else begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            key_len_reg  <= key_len_next;
            limit_reg    <= limit_next;
        end
    end

    // Clamp key length and buffer limit to what the scanner supports
    always_comb begin
        cfg.key  = {key_high_reg, key_low_reg};
        cfg.klen = (key_len_reg > KPOS_W'(KEY_MAX)) ? KPOS_W'(KEY_MAX) : key_len_reg;
        cfg.lim  = (limit_reg > LEN_W'(LIMIT_CAP)) ? LEN_W'(LIMIT_CAP) : limit_reg;
    end

endmodule

/* rtl/cove_scan.sv */
// Per-character scanner: word matching, value copy and line-end reporting.
// Depends on cove_pkg; produces up to two result beats per character.
module cove_scan
    import cove_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [CHAR_W-1:0] ch,
    input  cfg_t              cfg,
    output result_t           res0,
    output result_t           res1,
    output logic [1:0]        res_count
);

    localparam int LPOS_W = $clog2(LINE_CAPACITY);

    // Scan modes
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_CMP   = 3'd1;
    localparam logic [2:0] MODE_SKIP  = 3'd2;
    localparam logic [2:0] MODE_COPY  = 3'd3;
    localparam logic [2:0] MODE_DRAIN = 3'd4;

    logic [2:0]        mode_reg,   mode_next;
    logic [KPOS_W-1:0] kpos_reg,   kpos_next;
    logic [LEN_W-1:0]  vcount_reg, vcount_next;
    logic              seen_reg,   seen_next;
    logic [LPOS_W-1:0] lpos_reg,   lpos_next;

    logic              line_end;
    logic [CHAR_W-1:0] key_char;
    logic              bare_hit;
    logic              wr_emit;
    logic              term_emit;
    logic [LEN_W-1:0]  vcount_pre;
    logic              seen_pre;
    logic [LEN_W-1:0]  lim_m1;
    logic [LEN_W-1:0]  term_pos;
    result_t           bare_res;
    result_t           wr_res;
    result_t           term_res;

    assign line_end = (ch == CH_NUL) || (lpos_reg == LPOS_W'(LINE_CAPACITY - 1));
    assign key_char = cfg.key[{kpos_reg[3:0], 3'b000} +: CHAR_W];

    // Advance the scan state for one character
    always_comb begin
        mode_next   = mode_reg;
        kpos_next   = kpos_reg;
        vcount_next = vcount_reg;
        seen_next   = seen_reg;
        bare_hit    = 1'b0;
        wr_emit     = 1'b0;

        // A non-space at a word start opens a key compare
        if (mode_reg == MODE_START && ch != CH_SPACE) begin
            mode_next = MODE_CMP;
            kpos_next = '0;
        end

        if (mode_next == MODE_CMP) begin
            if (kpos_next >= cfg.klen) begin
                if (ch == CH_EQUAL) begin
                    vcount_next = '0;
                    seen_next   = 1'b1;
                    mode_next   = MODE_COPY;
                end else if (ch == CH_SPACE || ch == CH_NUL) begin
                    mode_next = MODE_DRAIN;
                    bare_hit  = 1'b1;
                end else begin
                    mode_next = MODE_SKIP;
                end
            end else if (ch == ((mode_reg == MODE_START) ? cfg.key[CHAR_W-1:0] : key_char))
            begin
                kpos_next = kpos_next + KPOS_W'(1);
            end else begin
                mode_next = MODE_SKIP;
            end
        end else if (mode_next == MODE_COPY) begin
            if (ch == CH_SPACE) begin
                mode_next = MODE_START;
            end else if (ch != CH_NUL) begin
                wr_emit = ({1'b0, vcount_reg} + (LEN_W+1)'(1)) < {1'b0, cfg.lim};
                if (vcount_reg != COUNT_MAX) begin
                    vcount_next = vcount_reg + LEN_W'(1);
                end
            end
        end

        // A space ends a skipped word
        if (mode_next == MODE_SKIP && ch == CH_SPACE) begin
            mode_next = MODE_START;
        end

        term_emit  = line_end && (mode_next != MODE_DRAIN);

        // Keep count and seen flag as the line-end report needs them
        vcount_pre = vcount_next;
        seen_pre   = seen_next;

        // Rearm for the next line, or count the position
        if (line_end) begin
            mode_next   = MODE_START;
            kpos_next   = '0;
            vcount_next = '0;
            seen_next   = 1'b0;
            lpos_next   = '0;
        end else begin
            lpos_next = lpos_reg + LPOS_W'(1);
        end
    end

    // Build the candidate result beats
    always_comb begin
        lim_m1   = cfg.lim - LEN_W'(1);
        term_pos = '0;

        bare_res             = '0;
        bare_res.done_res    = 1'b1;
        bare_res.status      = ST_BOOL;

        wr_res               = '0;
        wr_res.write_valid   = 1'b1;
        wr_res.write_index   = vcount_reg[IDX_W-1:0];
        wr_res.write_byte    = ch;
        wr_res.status        = ST_FOUND;

        term_res             = '0;
        term_res.write_valid = (cfg.lim != '0);
        if (cfg.lim != '0) begin
            term_pos = (vcount_pre < lim_m1) ? vcount_pre : lim_m1;
        end
        term_res.write_index = term_pos[IDX_W-1:0];
        term_res.done_res    = 1'b1;
        if (seen_pre) begin
            term_res.status       = ST_FOUND;
            term_res.value_length = vcount_pre;
        end else begin
            term_res.status       = ST_ABSENT;
        end
    end

    // Order the beats: bare key, value byte, terminator
    always_comb begin
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        if (bare_hit) begin
            res0      = bare_res;
            res_count = 2'd1;
        end else if (wr_emit && term_emit) begin
            res0      = wr_res;
            res1      = term_res;
            res_count = 2'd2;
        end else if (wr_emit) begin
            res0      = wr_res;
            res_count = 2'd1;
        end else if (term_emit) begin
            res0      = term_res;
            res_count = 2'd1;
        end
        res0.last = (res_count == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_START;
            kpos_reg   <= '0;
            vcount_reg <= '0;
            seen_reg   <= 1'b0;
            lpos_reg   <= '0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            kpos_reg   <= kpos_next;
            vcount_reg <= vcount_next;
            seen_reg   <= seen_next;
            lpos_reg   <= lpos_next;
        end
    end

endmodule

/* rtl/cove_rfifo.sv */
// Small result queue: takes up to two beats per cycle, hands out one.
// Depends on cove_pkg for the result type and the queue geometry.
module cove_rfifo
    import cove_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output logic       has_room,
    output logic       out_valid,
    output result_t    out_data
);

    result_t             mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0] count_reg,  count_next;
    logic [RQ_PTR_W-1:0] wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + RQ_PTR_W'(1);
    assign has_room  = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
        count_next  = count_reg + RQ_CNT_W'(push_count) - RQ_CNT_W'(pop);
    end

    // Store pushed beats
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/cove_checker.sv */
// Port-level checks for the option value extractor, bound to the top level.
// Depends on cove_pkg for the status codes.
module cove_port_props
    import cove_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_write_valid,
    input logic [IDX_W-1:0]  m_write_index,
    input logic [CHAR_W-1:0] m_write_byte,
    input logic              m_done_res,
    input logic [1:0]        m_status,
    input logic [LEN_W-1:0]  m_value_length,
    input logic              m_last
);

    // No result beat right after reset
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    // A stalled result beat holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_index)
            && $stable(m_write_byte) && $stable(m_status) && $stable(m_last))
        else $error("stalled result beat changed");

    // Only a value byte write can be followed by another beat of the same character
    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_write_valid && !m_done_res)
        else $error("non-final beat is not a value byte write");

    // A beat that does not finish the search carries status ST_FOUND and a zero length
    a_quiet_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_status == ST_FOUND && m_value_length == '0)
        else $error("status or length on a non-final search beat");

endmodule

bind cmdline_option_value_extractor cove_port_props u_cove_port_props (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_write_valid  (m_write_valid),
    .m_write_index  (m_write_index),
    .m_write_byte   (m_write_byte),
    .m_done_res     (m_done_res),
    .m_status       (m_status),
    .m_value_length (m_value_length),
    .m_last         (m_last)
);
